@@ hw/rtl/prime_field_arithmetic_unit_top_macros.svh @@
`ifndef PRIME_FIELD_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define PRIME_FIELD_ARITHMETIC_UNIT_TOP_MACROS_SVH

// checked property, held off while reset is low
`define PFAU_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// checked property, also sampled during reset
`define PFAU_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

@@ hw/rtl/pfau_pkg.sv @@
`timescale 1ns / 1ps

package pfau_pkg;

  localparam int unsigned MODULUS_DEFAULT = 32'd1000000007;

  localparam int OPCODE_W  = 3;
  localparam int OPERAND_W = 30;
  localparam int EXP_W     = 63;
  localparam int RESULT_W  = 30;

  localparam logic [OPCODE_W-1:0] OP_ADD = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MUL = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DIV = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_POW = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_INV = 3'd5;

endpackage

@@ hw/rtl/pfau_opred.sv @@
`timescale 1ns / 1ps

// reduces both raw operands by reciprocal multiplication and one correction
module pfau_opred #(
  parameter int unsigned MODULUS = pfau_pkg::MODULUS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [pfau_pkg::OPERAND_W-1:0]      a_in,
  input  logic [pfau_pkg::OPERAND_W-1:0]      b_in,
  output logic                                done,
  output logic [$clog2(MODULUS+1)-1:0]        a_out,
  output logic [$clog2(MODULUS+1)-1:0]        b_out
);

  localparam int K  = $clog2(MODULUS + 1);
  localparam int OW = pfau_pkg::OPERAND_W;
  // floor(2^30 / modulus); the quotient estimate falls short by one at most
  localparam logic [63:0]   MU_FULL = (64'd1 << OW) / 64'(MODULUS);
  localparam logic [OW-1:0] MU      = MU_FULL[OW-1:0];
  localparam logic [OW:0]   M_Q     = (OW+1)'(MODULUS);

  logic [2:0]      v_r;
  logic [OW-1:0]   sa_r, sb_r;
  logic [2*OW-1:0] pa_r, pb_r;
  logic [OW:0]     qma_r, qmb_r;

  logic [2*OW:0]   qma_full, qmb_full;
  logic [OW:0]     da, db;
  logic [OW:0]     ra, rb;

  // quotient times modulus, difference, one correction
  always_comb begin
    qma_full = (2*OW+1)'(pa_r[2*OW-1:OW]) * (2*OW+1)'(M_Q);
    qmb_full = (2*OW+1)'(pb_r[2*OW-1:OW]) * (2*OW+1)'(M_Q);
    da       = {1'b0, sa_r} - qma_r;
    db       = {1'b0, sb_r} - qmb_r;
    ra       = (da >= M_Q) ? (da - M_Q) : da;
    rb       = (db >= M_Q) ? (db - M_Q) : db;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sa_r <= a_in;
      sb_r <= b_in;
    end
    pa_r  <= (2*OW)'(sa_r) * (2*OW)'(MU);
    pb_r  <= (2*OW)'(sb_r) * (2*OW)'(MU);
    qma_r <= qma_full[OW:0];
    qmb_r <= qmb_full[OW:0];
  end

  assign done  = v_r[2];
  assign a_out = K'(ra[OW-1:0]);
  assign b_out = K'(rb[OW-1:0]);

endmodule

@@ hw/rtl/pfau_modmul.sv @@
`timescale 1ns / 1ps

// pipelined barrett modular multiplier
module pfau_modmul #(
  parameter int unsigned MODULUS = pfau_pkg::MODULUS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [$clog2(MODULUS+1)-1:0] x,
  input  logic [$clog2(MODULUS+1)-1:0] y,
  output logic                         done,
  output logic [$clog2(MODULUS+1)-1:0] z
);

  localparam int K = $clog2(MODULUS + 1);
  localparam logic [63:0]    MU_FULL = (64'd1 << (2 * K)) / 64'(MODULUS);
  localparam logic [K+1:0]   MU      = MU_FULL[K+1:0];
  localparam logic [K-1:0]   M_W     = K'(MODULUS);
  localparam logic [K+1:0]   M_X     = (K+2)'(MODULUS);

  logic [4:0]       v_r;
  logic [2*K-1:0]   p_r;
  logic [2*K+2:0]   q2_r;
  logic [K+1:0]     p2_r, p3_r;
  logic [K+1:0]     qm_r;
  logic [K+1:0]     r_r, r1_r;

  logic [2*K-1:0]   p_nxt;
  logic [2*K+2:0]   q2_nxt;
  logic [2*K+1:0]   qm_full;
  logic [K+1:0]     q;
  logic [K+1:0]     r1_nxt;
  logic [K+1:0]     z_full;

  always_comb begin
    p_nxt   = (2*K)'(x) * (2*K)'(y);
    q2_nxt  = (2*K+3)'(p_r[2*K-1:K-1]) * (2*K+3)'(MU);
    q       = q2_r[2*K+2:K+1];
    qm_full = (2*K+2)'(q) * (2*K+2)'(M_W);
    r1_nxt  = (r_r >= M_X) ? (r_r - M_X) : r_r;
    z_full  = (r1_r >= M_X) ? (r1_r - M_X) : r1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], start};
    end
  end

  // product, quotient estimate, quotient times modulus, difference, first correction
  always_ff @(posedge clk) begin
    p_r  <= p_nxt;
    q2_r <= q2_nxt;
    p2_r <= p_r[K+1:0];
    qm_r <= qm_full[K+1:0];
    p3_r <= p2_r;
    r_r  <= p3_r - qm_r;
    r1_r <= r1_nxt;
  end

  assign done = v_r[4];
  assign z    = z_full[K-1:0];

endmodule

@@ hw/rtl/prime_field_arithmetic_unit_top.sv @@
// sequence, accepting edge to strobe: operand reduction, then add, subtract and undefined opcodes
//   finish directly, multiply runs one product, power one square per bit up to the top set bit
//   and one product per set bit; inverse is a power to modulus-2, divide that power of b then one product
// throughput: one word at a time, busy holds through the strobe; the barrett multiplier is shared
//   and the operand reduction runs before every word
// reset: synchronous active-low, sequencer back to idle; results cannot be stalled
`timescale 1ns / 1ps

`include "prime_field_arithmetic_unit_top_macros.svh"

module prime_field_arithmetic_unit_top #(
  parameter int unsigned MODULUS = pfau_pkg::MODULUS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [pfau_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [pfau_pkg::OPERAND_W-1:0]   in_operand_a,
  input  logic [pfau_pkg::OPERAND_W-1:0]   in_operand_b,
  input  logic [pfau_pkg::EXP_W-1:0]       in_exponent,
  output logic                             out_strobe,
  output logic [pfau_pkg::RESULT_W-1:0]    out_result
);

  // residue width follows the modulus
  localparam int K = $clog2(MODULUS + 1);
  localparam logic [K:0]                   M_EXT   = (K+1)'(MODULUS);
  localparam logic [pfau_pkg::EXP_W-1:0]   EXP_INV = pfau_pkg::EXP_W'(MODULUS - 2);
  localparam logic [K-1:0]                 ONE     = K'(1);

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RED  = 8'b0000_0010, // operand reduction running
    S_DISP = 8'b0000_0100, // pick the operation
    S_BIT  = 8'b0000_1000, // look at the next exponent bit
    S_MULW = 8'b0001_0000, // waiting on acc * base
    S_SQRW = 8'b0010_0000, // waiting on base * base
    S_LAST = 8'b0100_0000, // waiting on the closing product
    S_DONE = 8'b1000_0000  // result strobe
  } state_t;

  state_t state_r, state_nxt;

  // item registers
  logic [pfau_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic [pfau_pkg::EXP_W-1:0]    e_r, e_nxt;
  logic [K-1:0]                  a_r, a_nxt;
  logic [K-1:0]                  b_r, b_nxt;
  logic [K-1:0]                  acc_r, acc_nxt;
  logic [K-1:0]                  base_r, base_nxt;

  // shared multiplier port
  logic         mm_start;
  logic [K-1:0] mm_x, mm_y;
  logic         mm_done;
  logic [K-1:0] mm_z;
  logic         mm_wait;

  // operand reduction unit
  logic         red_start;
  logic         red_done;
  logic [K-1:0] red_a, red_b;

  logic [K:0]   sum_add, sum_sub;
  logic [K-1:0] res_add, res_sub;
  logic [31:0]  acc_ext;

  assign red_start = start && state_r == S_IDLE;

  pfau_opred #(
    .MODULUS (MODULUS)
  ) u_opred (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .a_in  (in_operand_a),
    .b_in  (in_operand_b),
    .done  (red_done),
    .a_out (red_a),
    .b_out (red_b)
  );

  pfau_modmul #(
    .MODULUS (MODULUS)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .x     (mm_x),
    .y     (mm_y),
    .done  (mm_done),
    .z     (mm_z)
  );

  // modular add and subtract sit beside the sequencer, one compare each
  always_comb begin
    sum_add = (K+1)'(a_r) + (K+1)'(b_r);
    sum_sub = (K+1)'(a_r) + (M_EXT - (K+1)'(b_r));
    res_add = (sum_add >= M_EXT) ? K'(sum_add - M_EXT) : sum_add[K-1:0];
    res_sub = (sum_sub >= M_EXT) ? K'(sum_sub - M_EXT) : sum_sub[K-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    e_nxt     = e_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    mm_start  = 1'b0;
    mm_x      = acc_r;
    mm_y      = base_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_opcode;
          e_nxt     = in_exponent;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (red_done) begin
          a_nxt     = red_a;
          b_nxt     = red_b;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        acc_nxt   = ONE;
        base_nxt  = a_r;
        state_nxt = S_BIT;
        unique case (op_r)
          pfau_pkg::OP_ADD: begin
            acc_nxt   = res_add;
            state_nxt = S_DONE;
          end
          pfau_pkg::OP_SUB: begin
            acc_nxt   = res_sub;
            state_nxt = S_DONE;
          end
          pfau_pkg::OP_MUL: begin
            mm_start  = 1'b1;
            mm_x      = a_r;
            mm_y      = b_r;
            state_nxt = S_LAST;
          end
          pfau_pkg::OP_DIV: begin
            // inverse of b first, then times a
            base_nxt = b_r;
            e_nxt    = EXP_INV;
          end
          pfau_pkg::OP_POW: begin
          end
          pfau_pkg::OP_INV: begin
            e_nxt = EXP_INV;
          end
          default: begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_BIT: begin
        if (e_r == '0) begin
          if (op_r == pfau_pkg::OP_DIV) begin
            mm_start  = 1'b1;
            mm_x      = acc_r;
            mm_y      = a_r;
            state_nxt = S_LAST;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (e_r[0]) begin
          mm_start  = 1'b1;
          state_nxt = S_MULW;
        end else begin
          mm_start  = 1'b1;
          mm_x      = base_r;
          state_nxt = S_SQRW;
        end
      end
      S_MULW: begin
        if (mm_done) begin
          acc_nxt   = mm_z;
          mm_start  = 1'b1;
          mm_x      = base_r;
          state_nxt = S_SQRW;
        end
      end
      S_SQRW: begin
        if (mm_done) begin
          base_nxt  = mm_z;
          e_nxt     = e_r >> 1;
          state_nxt = S_BIT;
        end
      end
      S_LAST: begin
        if (mm_done) begin
          acc_nxt   = mm_z;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    e_r    <= e_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
  end

  // result word is the residue cut to 30 bits
  assign acc_ext    = 32'(acc_r);
  assign busy       = state_r != S_IDLE;
  assign out_strobe = state_r == S_DONE;
  assign out_result = acc_ext[pfau_pkg::RESULT_W-1:0];

  // states that expect a product back from the multiplier
  assign mm_wait = state_r == S_MULW || state_r == S_SQRW || state_r == S_LAST;

  // checks
  `PFAU_ASSERT(a_strobe_single, clk, rst_n, out_strobe |=> !out_strobe, "strobe held over")
  `PFAU_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "busy not raised")
  `PFAU_ASSERT(a_mm_expected, clk, rst_n, mm_done |-> mm_wait, "stray product")
  `PFAU_ASSERT(a_res_reduced, clk, rst_n, out_strobe |-> 32'(out_result) < MODULUS, "unreduced")
  `PFAU_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy, "busy after reset")

endmodule

@@ tb/sv/tb_prime_field_arithmetic_unit_top.sv @@
`timescale 1ns / 1ps

module tb_prime_field_arithmetic_unit_top;

  typedef logic [pfau_pkg::OPCODE_W-1:0]  opcode_t;
  typedef logic [pfau_pkg::OPERAND_W-1:0] operand_t;
  typedef logic [pfau_pkg::EXP_W-1:0]     exp_t;
  typedef logic [pfau_pkg::RESULT_W-1:0]  result_t;

  // prime the block is built for; the instance keeps its default
  localparam longint unsigned FIELD_PRIME = longint'(pfau_pkg::MODULUS_DEFAULT);

  // opcodes the block does not define: both must give a zero residue
  localparam opcode_t OP_RSVD_LO = 3'd6;
  localparam opcode_t OP_RSVD_HI = 3'd7;

  // handy residues and field extremes
  localparam operand_t RES_TOP    = operand_t'(FIELD_PRIME - 1);
  localparam operand_t RES_PRIME  = operand_t'(FIELD_PRIME);
  localparam operand_t OPND_ONES  = '1;
  localparam exp_t     EXP_ONES   = '1;

  localparam int NUM_RANDOM     = 1200;
  // covers the slowest word, a full-width power, plus the longest sender gap
  localparam int TAIL_CYCLES    = 1000;
  localparam int WATCHDOG_LIMIT = 5000;

  // one row of the directed table; fixed marks a residue typed in by hand
  typedef struct packed {
    opcode_t  opcode;
    operand_t a;
    operand_t b;
    exp_t     e;
    logic     fixed;
    result_t  want;
  } directed_word_t;

  localparam int NUM_DIRECTED = 25;

  directed_word_t directed_words [NUM_DIRECTED] = '{
    // add: zero, wrap to zero at the prime, unreduced all-ones operands
    '{pfau_pkg::OP_ADD, 30'd0,     30'd0,     63'd0,    1'b1, 30'd0},
    '{pfau_pkg::OP_ADD, RES_TOP,   30'd1,     63'd0,    1'b1, 30'd0},
    '{pfau_pkg::OP_ADD, OPND_ONES, OPND_ONES, EXP_ONES, 1'b0, 30'd0},
    // subtract: borrow below zero, unreduced operand equal to the prime
    '{pfau_pkg::OP_SUB, 30'd0,     30'd1,     63'd0,    1'b1, RES_TOP},
    '{pfau_pkg::OP_SUB, RES_PRIME, 30'd0,     63'd0,    1'b1, 30'd0},
    '{pfau_pkg::OP_SUB, OPND_ONES, RES_TOP,   63'd0,    1'b0, 30'd0},
    // multiply: minus one squared, zero factor, largest unreduced product
    '{pfau_pkg::OP_MUL, RES_TOP,   RES_TOP,   63'd0,    1'b1, 30'd1},
    '{pfau_pkg::OP_MUL, 30'd0,     OPND_ONES, 63'd0,    1'b1, 30'd0},
    '{pfau_pkg::OP_MUL, OPND_ONES, OPND_ONES, 63'd0,    1'b0, 30'd0},
    // divide: by zero, zero dividend, all-ones by minus one, by an unreduced zero
    '{pfau_pkg::OP_DIV, 30'd7,     30'd0,     63'd0,    1'b1, 30'd0},
    '{pfau_pkg::OP_DIV, 30'd0,     30'd5,     63'd0,    1'b1, 30'd0},
    '{pfau_pkg::OP_DIV, OPND_ONES, RES_TOP,   63'd0,    1'b0, 30'd0},
    '{pfau_pkg::OP_DIV, 30'd1,     RES_PRIME, 63'd0,    1'b1, 30'd0},
    // power: zero exponent (0^0 too), small powers, all-ones exponent
    '{pfau_pkg::OP_POW, 30'd0,     30'd0,     63'd0,    1'b1, 30'd1},
    '{pfau_pkg::OP_POW, 30'd5,     30'd0,     63'd0,    1'b1, 30'd1},
    '{pfau_pkg::OP_POW, 30'd0,     30'd0,     63'd1,    1'b1, 30'd0},
    '{pfau_pkg::OP_POW, 30'd2,     30'd0,     63'd10,   1'b1, 30'd1024},
    '{pfau_pkg::OP_POW, RES_TOP,   30'd0,     EXP_ONES, 1'b1, RES_TOP},
    '{pfau_pkg::OP_POW, OPND_ONES, 30'd0,     EXP_ONES, 1'b0, 30'd0},
    // inverse: of zero, one, minus one, unreduced all-ones
    '{pfau_pkg::OP_INV, 30'd0,     30'd0,     63'd0,    1'b1, 30'd0},
    '{pfau_pkg::OP_INV, 30'd1,     30'd0,     63'd0,    1'b1, 30'd1},
    '{pfau_pkg::OP_INV, RES_TOP,   30'd0,     63'd0,    1'b1, RES_TOP},
    '{pfau_pkg::OP_INV, OPND_ONES, 30'd0,     63'd0,    1'b0, 30'd0},
    // undefined opcodes with every other bit set
    '{OP_RSVD_LO,       OPND_ONES, OPND_ONES, EXP_ONES, 1'b1, 30'd0},
    '{OP_RSVD_HI,       OPND_ONES, OPND_ONES, EXP_ONES, 1'b1, 30'd0}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  opcode_t  in_opcode = '0;
  operand_t in_operand_a = '0;
  operand_t in_operand_b = '0;
  exp_t     in_exponent = '0;
  logic     out_strobe;
  result_t  out_result;

  // residues still owed by the block, oldest first
  result_t pending_residues [$];
  result_t expected_residue;
  int      mismatch_count = 0;
  int      quiet_cycles = 0;

  prime_field_arithmetic_unit_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_exponent  (in_exponent),
    .out_strobe   (out_strobe),
    .out_result   (out_result)
  );

  // 8 ns period
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // residue arithmetic over the prime field
  // ---------------------------------------------------------------------

  // both factors are below 2^31, so the product fits in 64 bits
  function automatic longint unsigned field_mul(input longint unsigned x,
                                                input longint unsigned y);
    return (x * y) % FIELD_PRIME;
  endfunction

  // square-and-multiply, exponent bits taken from the lsb upward
  function automatic longint unsigned field_pow(input longint unsigned base,
                                                input exp_t e);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1 % FIELD_PRIME;
    sq  = base;
    for (int i = 0; i < pfau_pkg::EXP_W; i++) begin
      if (e[i]) acc = field_mul(acc, sq);
      sq = field_mul(sq, sq);
    end
    return acc;
  endfunction

  // residue the block must return for one word
  function automatic result_t predict_residue(input opcode_t  op,
                                              input operand_t a,
                                              input operand_t b,
                                              input exp_t     e);
    longint unsigned ra;
    longint unsigned rb;
    longint unsigned r;
    exp_t fermat_exp;
    // operands at or above the prime are reduced first
    ra = longint'(a) % FIELD_PRIME;
    rb = longint'(b) % FIELD_PRIME;
    fermat_exp = exp_t'(FIELD_PRIME - 2);
    case (op)
      pfau_pkg::OP_ADD: begin
        r = ra + rb;
        if (r >= FIELD_PRIME) r = r - FIELD_PRIME;
      end
      pfau_pkg::OP_SUB: begin
        r = ra + (FIELD_PRIME - rb);
        if (r >= FIELD_PRIME) r = r - FIELD_PRIME;
      end
      pfau_pkg::OP_MUL: r = field_mul(ra, rb);
      // the inverse of zero comes out as zero, so divide by zero does too
      pfau_pkg::OP_DIV: r = field_mul(ra, field_pow(rb, fermat_exp));
      pfau_pkg::OP_POW: r = field_pow(ra, e);
      pfau_pkg::OP_INV: r = field_pow(ra, fermat_exp);
      default: r = 0;
    endcase
    return r[pfau_pkg::RESULT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // random field values
  // ---------------------------------------------------------------------

  // residues, extremes, unreduced values and raw 30-bit patterns
  function automatic operand_t pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return operand_t'(1);
      2: return RES_TOP;
      3: return operand_t'($urandom_range(int'(FIELD_PRIME), (1 << pfau_pkg::OPERAND_W) - 1));
      4: return operand_t'($urandom);
      default: return operand_t'($urandom_range(0, int'(FIELD_PRIME - 1)));
    endcase
  endfunction

  // short exponents, full-width ones and everything between
  function automatic exp_t pick_exponent();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return exp_t'($urandom_range(0, 70));
      1: return raw[pfau_pkg::EXP_W-1:0];
      2: return raw[pfau_pkg::EXP_W-1:0] >> $urandom_range(1, pfau_pkg::EXP_W - 1);
      3: return exp_t'(1) << $urandom_range(0, pfau_pkg::EXP_W - 1);
      default: return EXP_ONES;
    endcase
  endfunction

  // mostly back-to-back or short, now and then a long pause
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // ---------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------

  // offer one word and hold it until the block takes it; start is left high
  task automatic send_word(input opcode_t  op,
                           input operand_t a,
                           input operand_t b,
                           input exp_t     e,
                           input logic     fixed,
                           input result_t  want);
    start        <= 1'b1;
    in_opcode    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    in_exponent  <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge
    pending_residues.push_back(fixed ? want : predict_residue(op, a, b, e));
  endtask

  // drop start for a while, with junk on the fields that must be ignored
  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start        <= 1'b0;
      in_opcode    <= opcode_t'($urandom);
      in_operand_a <= operand_t'($urandom);
      in_operand_b <= operand_t'($urandom);
      in_exponent  <= exp_t'({$urandom, $urandom});
      repeat (cycles) @(posedge clk);
    end
  endtask

  // hold off until every owed residue has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
  endtask

  initial begin
    opcode_t op;
    // synchronous reset, once, before any word
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table first
    foreach (directed_words[i]) begin
      send_word(directed_words[i].opcode, directed_words[i].a, directed_words[i].b,
                directed_words[i].e, directed_words[i].fixed, directed_words[i].want);
      idle_for(pick_gap());
    end
    wait_drained();

    // random words; every third block of 150 runs with no idle gaps, only the occasional drain
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if ($urandom_range(0, 19) == 0) op = opcode_t'($urandom_range(6, 7));
      else op = opcode_t'($urandom_range(0, 5));
      send_word(op, pick_operand(), pick_operand(), pick_exponent(), 1'b0, '0);
      if (n == NUM_RANDOM / 2 || $urandom_range(0, 99) == 0) wait_drained();
      else if ((n / 150) % 3 != 1) idle_for(pick_gap());
    end

    // drain, then give a stray extra result time to show itself
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // result checking: each strobe is matched against the oldest owed residue
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_residues.size() == 0) begin
        $display("%0t: result with nothing owed: expected none, actual %0d",
                 $time, out_result);
        mismatch_count++;
      end else begin
        expected_residue = pending_residues.pop_front();
        if (out_result !== expected_residue) begin
          $display("%0t: result mismatch: expected %0d, actual %0d",
                   $time, expected_residue, out_result);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: any accepted word or result resets the count
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_strobe)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
